// ===== hdl/dris_pkg.sv =====
// ----------------------------------------------------------------------------
// dris_pkg: shared types and constants for the date record insertion sorter
// Key layout, default store depth and the link passed between sorter cells.
// ----------------------------------------------------------------------------
package dris_pkg;

   // field widths of one date record
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 12;
   localparam int KEY_W   = DAY_W + MONTH_W + YEAR_W;

   // default number of cells in the chain
   localparam int CAPACITY_DEFAULT = 16;

   // sort key: year, then month, then day
   typedef logic [KEY_W-1:0] key_type;

   // data handed from one cell to its upper neighbor during an insert
   typedef struct packed {
      key_type key;   // stored key
      logic    gt;    // cell is empty or holds a key greater than the new one
   } link_type;

endpackage

// ===== hdl/dris_cell.sv =====
// ----------------------------------------------------------------------------
// dris_cell: one slot of the insertion chain
// Holds one key; on insert it keeps, takes the new key or takes its lower
// neighbor's key; on flush it takes its upper neighbor's key.
// ----------------------------------------------------------------------------
module dris_cell (
   input  logic               clock,
   input  logic               ins,        // insert the broadcast key this cycle
   input  logic               shl,        // flush: move chain toward cell 0
   input  logic               occ,        // this slot holds a record
   input  dris_pkg::key_type  ins_key,    // broadcast key being inserted
   input  dris_pkg::link_type prev_link,  // from the cell below
   input  dris_pkg::key_type  next_key,   // from the cell above, used on flush
   output dris_pkg::link_type link        // to the cell above
);

   dris_pkg::key_type key_ff;
   dris_pkg::key_type key_in;
   logic              gt;

   // empty slots count as greater, ties stay put for stability
   assign gt = !occ || (key_ff > ins_key);

   assign link.key = key_ff;
   assign link.gt  = gt;

   // next key
   always_comb begin
      key_in = key_ff;
      if (shl) begin
         key_in = next_key;
      end else if (ins) begin
         if (prev_link.gt) begin
            key_in = prev_link.key;
         end else if (gt) begin
            key_in = ins_key;
         end
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

// ===== hdl/date_record_insertion_sorter_unit.sv =====
// ----------------------------------------------------------------------------
// date_record_insertion_sorter_unit: stable insertion sorter for date records
// Insert: a record is placed in the chain in the cycle after it is accepted.
// Throughput: one record per cycle when not busy; a last record starts a
// flush of the N stored records, one result per cycle, the first result
// registered after the flush register is set. busy is high during the flush.
// Reset: synchronous, clears the record count, overflow, flush and strobe.
// ----------------------------------------------------------------------------
module date_record_insertion_sorter_unit #(
   parameter int CAPACITY = dris_pkg::CAPACITY_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [dris_pkg::DAY_W-1:0]   req_day,
   input  logic [dris_pkg::MONTH_W-1:0] req_month,
   input  logic [dris_pkg::YEAR_W-1:0]  req_year,
   input  logic                         req_last_item,
   output logic                         rsp_strobe,
   output logic [dris_pkg::DAY_W-1:0]   rsp_out_day,
   output logic [dris_pkg::MONTH_W-1:0] rsp_out_month,
   output logic [dris_pkg::YEAR_W-1:0]  rsp_out_year,
   output logic                         rsp_out_last,
   output logic                         rsp_overflow
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int MW    = dris_pkg::DAY_W;
   localparam int YL    = dris_pkg::DAY_W + dris_pkg::MONTH_W;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic               flush_ff, flush_in;
   logic               ovf_ff, ovf_in;
   logic               strobe_ff, strobe_in;
   logic               last_ff, last_in;
   logic               rovf_ff, rovf_in;
   dris_pkg::key_type  rkey_ff, rkey_in;

   logic               accept;
   logic               full;
   logic               ins;
   dris_pkg::key_type  new_key;
   dris_pkg::link_type links [CAPACITY];

   assign accept  = start && !busy;
   assign full    = (count_ff == CNT_W'(CAPACITY));
   assign ins     = accept && !full;
   assign new_key = {req_year, req_month, req_day};
   assign busy    = flush_ff;

   // chain of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      dris_pkg::link_type prev_link;
      dris_pkg::key_type  next_key;
      if (i == 0) begin : g_first
         assign prev_link = '{key: '0, gt: 1'b0};
      end else begin : g_mid
         assign prev_link = links[i-1];
      end
      if (i == CAPACITY - 1) begin : g_top
         assign next_key = links[i].key;
      end else begin : g_below
         assign next_key = links[i+1].key;
      end
      dris_cell u_cell (
         .clock     (clock),
         .ins       (ins),
         .shl       (flush_ff),
         .occ       (CNT_W'(i) < count_ff),
         .ins_key   (new_key),
         .prev_link (prev_link),
         .next_key  (next_key),
         .link      (links[i])
      );
   end

   // control: insert, flush sequencing, result register
   always_comb begin
      count_in  = count_ff;
      flush_in  = flush_ff;
      ovf_in    = ovf_ff;
      strobe_in = 1'b0;
      last_in   = last_ff;
      rovf_in   = rovf_ff;
      rkey_in   = rkey_ff;
      if (flush_ff) begin
         strobe_in = 1'b1;
         rkey_in   = links[0].key;
         last_in   = (count_ff == CNT_W'(1));
         rovf_in   = ovf_ff;
         count_in  = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            flush_in = 1'b0;
            ovf_in   = 1'b0;
         end
      end else if (accept) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
         if (req_last_item) begin
            flush_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         flush_ff  <= 1'b0;
         ovf_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         flush_ff  <= flush_in;
         ovf_ff    <= ovf_in;
         strobe_ff <= strobe_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      last_ff <= last_in;
      rovf_ff <= rovf_in;
      rkey_ff <= rkey_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_out_day   = rkey_ff[MW-1:0];
   assign rsp_out_month = rkey_ff[YL-1:MW];
   assign rsp_out_year  = rkey_ff[dris_pkg::KEY_W-1:YL];
   assign rsp_out_last  = last_ff;
   assign rsp_overflow  = rovf_ff;

endmodule
